>>> sv/sgbpr_pkg.sv
// Shared types and constants of the joypad packet receiver.
package sgbpr_pkg;

  localparam int PktBytes = 16;
  localparam int PktAw    = $clog2(PktBytes);
  localparam int MaxPlayers = 4;
  localparam int PlayerAw   = $clog2(MaxPlayers);

  localparam logic [7:0] PORT_RESET = 8'h00;
  localparam logic [7:0] PORT_ARM   = 8'h30;
  localparam logic [7:0] PORT_ZERO  = 8'h20;
  localparam logic [7:0] PORT_ONE   = 8'h10;
  localparam int         PortSelBit = 5;

  localparam logic [1:0] FUNC_PORT      = 2'd0;
  localparam logic [1:0] FUNC_PKT_READ  = 2'd1;
  localparam logic [1:0] FUNC_JOY_WRITE = 2'd2;
  localparam logic [1:0] FUNC_JOY_READ  = 2'd3;

  localparam logic [1:0] MODE_ONE = 2'd0;
  localparam logic [1:0] MODE_TWO = 2'd1;

  localparam logic [3:0] CODE_BASE = 4'hF;

  // Per-beat decisions from the port decoder to the datapath.
  typedef struct packed {
    logic                wr;        // read-modify-write one packet bit
    logic [2:0]          bit_idx;
    logic                bit_val;
    logic                done;
    logic                seq_abort;
    logic                ready;     // packet ready after this beat
    logic [PlayerAw-1:0] player;    // player index after this beat
  } sgbpr_op_t;

  function automatic logic [PlayerAw-1:0] player_mask(input logic [1:0] mode);
    logic [PlayerAw-1:0] m;
    unique case (mode)
      MODE_ONE: m = 2'd0;
      MODE_TWO: m = 2'd1;
      default:  m = 2'd3;
    endcase
    return m;
  endfunction

endpackage

>>> sv/sgbpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgbpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/sgbpr_ctrl.sv
// Port-write decoder: reception sequencer, bit position, ready flag and player select.
module sgbpr_ctrl import sgbpr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          func,
  input  logic [7:0]          data_value,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_mode,
  output sgbpr_op_t           op,
  output logic [PktAw-1:0]    byte_addr,
  output logic [PlayerAw-1:0] player_index
);

  logic [7:0]          last_port, last_port_next;
  logic                wait_high, wait_high_next;
  logic                listening, listening_next;
  logic                ready_flag, ready_flag_next;
  logic [4:0]          byte_pos, byte_pos_next;
  logic [2:0]          bit_pos, bit_pos_next;
  logic [PlayerAw-1:0] player_index_next;
  logic [1:0]          player_mode;
  logic                advance;
  logic                full;

  assign full      = byte_pos[PktAw];
  assign byte_addr = byte_pos[PktAw-1:0];

  always_comb begin
    last_port_next    = last_port;
    wait_high_next    = wait_high;
    listening_next    = listening;
    ready_flag_next   = ready_flag;
    player_index_next = player_index;
    advance           = 1'b0;
    op                = '0;

    if (func == FUNC_PKT_READ) begin
      ready_flag_next = 1'b0;
    end else if (func == FUNC_PORT && data_value != last_port) begin
      last_port_next = data_value;
      priority if (data_value == PORT_RESET) begin
        wait_high_next = 1'b1;
      end else if (wait_high) begin
        if (data_value == PORT_ONE || data_value == PORT_ZERO) begin
          wait_high_next = 1'b0;
          listening_next = 1'b0;
          op.seq_abort   = 1'b1;
        end else if (data_value == PORT_ARM) begin
          wait_high_next = 1'b0;
          listening_next = 1'b1;
        end
      end else if (listening) begin
        if (data_value == PORT_ZERO) begin
          if (full && bit_pos == 3'd0) begin
            ready_flag_next = 1'b1;
            listening_next  = 1'b0;
            op.done         = 1'b1;
          end else if (!full) begin
            op.wr = 1'b1;
          end
          advance = 1'b1;
        end else if (data_value == PORT_ONE) begin
          if (full) begin
            listening_next = 1'b0;
            op.seq_abort   = 1'b1;
          end else begin
            op.wr      = 1'b1;
            op.bit_val = 1'b1;
            advance    = 1'b1;
          end
        end
        wait_high_next = listening_next;
      end else begin
        // between packets: rising edge on the select bit steps the player
        if (!last_port[PortSelBit] && data_value[PortSelBit]) begin
          player_index_next = (player_index + 1'b1) & player_mask(player_mode);
        end
      end
    end

    // position counters: bit LSB first, byte wraps in five bits
    byte_pos_next = byte_pos;
    bit_pos_next  = bit_pos;
    if (func == FUNC_PORT && data_value != last_port && data_value == PORT_RESET) begin
      byte_pos_next = '0;
      bit_pos_next  = '0;
    end else if (advance) begin
      bit_pos_next = bit_pos + 3'd1;
      if (bit_pos == 3'd7) begin
        byte_pos_next = byte_pos + 5'd1;
      end
    end

    op.bit_idx = bit_pos;
    op.ready   = ready_flag_next;
    op.player  = player_index_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_port    <= '0;
      wait_high    <= 1'b1;
      listening    <= 1'b0;
      ready_flag   <= 1'b0;
      byte_pos     <= '0;
      bit_pos      <= '0;
      player_index <= '0;
      player_mode  <= MODE_ONE;
    end else if (cfg_we) begin
      player_mode  <= cfg_mode;
      player_index <= player_index & player_mask(cfg_mode);
    end else if (accept) begin
      last_port    <= last_port_next;
      wait_high    <= wait_high_next;
      listening    <= listening_next;
      ready_flag   <= ready_flag_next;
      byte_pos     <= byte_pos_next;
      bit_pos      <= bit_pos_next;
      player_index <= player_index_next;
    end
  end

endmodule

>>> sv/sgb_packet_receiver_unit.sv
// Joypad-port packet receiver: top level with packet and joypad memories and output stage.
// Accepts one beat per cycle while the output is not stalled, returning one result beat for
// each via stage 1 and the output register. Sequencing state sits in the decoder; packet
// bytes live in a 16x8 RAM updated by read-modify-write one stage after acceptance, with a
// one-deep bypass for back-to-back bits into the same byte; joypad bytes live in a 4x8 RAM.
// Entries read as zero until first written (valid bits cleared by reset). The player_mode
// register is written through the cfg channel; a cfg beat holds off the input for its cycle.
module sgb_packet_receiver_unit import sgbpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [7:0] data_value,
  input  logic [3:0] slot,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic [3:0] player_code,
  output logic       packet_ready,
  output logic       packet_done,
  output logic       sequence_abort
);

  logic                in_acc;
  logic                cfg_we;
  sgbpr_op_t           op;
  logic [PktAw-1:0]    byte_addr;
  logic [PlayerAw-1:0] player_index;

  // stage 1: memory data returns
  logic                s1_valid;
  logic                s1_adv;
  logic [1:0]          s1_func;
  sgbpr_op_t           s1_op;
  logic [PktAw-1:0]    s1_addr;
  logic                s1_pvld;
  logic                s1_jvld;
  logic                s1_fwd;
  logic [7:0]          s1_fwd_data;

  logic [PktBytes-1:0]   pkt_vld;
  logic [MaxPlayers-1:0] joy_vld;
  logic [PktAw-1:0]      pkt_raddr;
  logic [7:0]            pkt_rdata;
  logic [7:0]            joy_rdata;
  logic [7:0]            pkt_base;
  logic [7:0]            pkt_new;
  logic [7:0]            bit_mask;
  logic                  pkt_we;
  logic                  joy_we;
  logic [7:0]            rd_sel;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = (!s1_valid || s1_adv) && !cfg_valid;
  assign in_acc    = in_valid && in_ready;
  assign pkt_raddr = (func == FUNC_PKT_READ) ? slot : byte_addr;
  assign pkt_we    = s1_adv && s1_op.wr;
  assign joy_we    = in_acc && func == FUNC_JOY_WRITE;

  sgbpr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_acc),
    .func         (func),
    .data_value   (data_value),
    .cfg_we       (cfg_we),
    .cfg_mode     (cfg_data),
    .op           (op),
    .byte_addr    (byte_addr),
    .player_index (player_index)
  );

  sgbpr_ram #(.WIDTH(8), .DEPTH(PktBytes)) u_pkt_ram (
    .clk   (clk),
    .we    (pkt_we),
    .waddr (s1_addr),
    .wdata (pkt_new),
    .re    (in_acc),
    .raddr (pkt_raddr),
    .rdata (pkt_rdata)
  );

  sgbpr_ram #(.WIDTH(8), .DEPTH(MaxPlayers)) u_joy_ram (
    .clk   (clk),
    .we    (joy_we),
    .waddr (slot[PlayerAw-1:0]),
    .wdata (data_value),
    .re    (in_acc),
    .raddr (player_index),
    .rdata (joy_rdata)
  );

  // bit merge; bypass covers a write landing on the same edge as this beat's read
  always_comb begin
    pkt_base = s1_fwd ? s1_fwd_data : (s1_pvld ? pkt_rdata : 8'h00);
    bit_mask = 8'h01 << s1_op.bit_idx;
    pkt_new  = s1_op.bit_val ? (pkt_base | bit_mask) : (pkt_base & ~bit_mask);
    unique case (s1_func)
      FUNC_PKT_READ: rd_sel = pkt_base;
      FUNC_JOY_READ: rd_sel = s1_jvld ? joy_rdata : 8'h00;
      default:       rd_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      pkt_vld   <= '0;
      joy_vld   <= '0;
    end else begin
      if (in_acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pkt_we) begin
        pkt_vld[s1_addr] <= 1'b1;
      end
      if (joy_we) begin
        joy_vld[slot[PlayerAw-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func     <= func;
      s1_op       <= op;
      s1_addr     <= pkt_raddr;
      s1_pvld     <= pkt_vld[pkt_raddr];
      s1_jvld     <= joy_vld[player_index];
      s1_fwd      <= pkt_we && s1_addr == pkt_raddr;
      s1_fwd_data <= pkt_new;
    end
    if (s1_adv) begin
      read_data      <= rd_sel;
      player_code    <= CODE_BASE - {{(4 - PlayerAw){1'b0}}, s1_op.player};
      packet_ready   <= s1_op.ready;
      packet_done    <= s1_op.done;
      sequence_abort <= s1_op.seq_abort;
    end
  end

  a_done_sets_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && packet_done |-> packet_ready)
    else $error("packet_done without packet_ready");

  a_done_abort_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(packet_done && sequence_abort))
    else $error("packet_done and sequence_abort on one beat");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> player_code[3:2] == 2'b11)
    else $error("player_code out of range");

  a_bypass_same_byte: assert property (@(posedge clk) disable iff (rst)
    in_acc && pkt_we && s1_addr == pkt_raddr |=> s1_fwd)
    else $error("missed bypass on same packet byte");

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the joypad-port packet receiver.
`timescale 1ns / 100ps

module tb_top;
  import sgbpr_pkg::*;

  localparam int ItemTarget = 1950;
  localparam int PhaseItems = 160;
  localparam int HoldCycles = 150;
  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] player_code;
    logic       packet_ready;
    logic       packet_done;
    logic       sequence_abort;
  } resp_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data;
    logic [3:0] slot;
    logic       typed;
    resp_t      want;
  } vec_t;

  localparam resp_t NO_RESP = '0;
  localparam resp_t QUIET_F = '{8'h00, CODE_BASE, 1'b0, 1'b0, 1'b0};
  localparam resp_t ABORT_F = '{8'h00, CODE_BASE, 1'b0, 1'b0, 1'b1};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_data = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] func = FUNC_PORT;
  logic [7:0] data_value = 8'h00;
  logic [3:0] slot = 4'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] read_data;
  logic [3:0] player_code;
  logic       packet_ready;
  logic       packet_done;
  logic       sequence_abort;

  // receiver copy of the block state
  logic [1:0] seat_mode = MODE_ONE;
  logic [7:0] port_prev = PORT_RESET;
  logic       want_arm = 1'b1;
  logic       rx_on = 1'b0;
  logic       pkt_full = 1'b0;
  logic [4:0] byte_ptr = '0;
  logic [2:0] bit_ptr = '0;
  logic [7:0] pkt_bytes [PktBytes] = '{default: 8'h00};
  logic [1:0] seat = '0;
  logic [7:0] pad_bytes [MaxPlayers] = '{default: 8'h00};

  resp_t reply_due [$];
  resp_t due;
  int    errors = 0;
  int    items_done = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;
  int    hold_req = 0;
  int    hold_ack = 0;
  int    hold_left = 0;
  int    cycle_cnt = 0;
  vec_t  dir_tab [22];

  sgb_packet_receiver_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .data_value     (data_value),
    .slot           (slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .player_code    (player_code),
    .packet_ready   (packet_ready),
    .packet_done    (packet_done),
    .sequence_abort (sequence_abort)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [1:0] seat_mask();
    return (seat_mode == MODE_ONE) ? 2'd0 : (seat_mode == MODE_TWO) ? 2'd1 : 2'd3;
  endfunction

  // Advances the state copy by one beat and returns the reply it causes.
  function automatic resp_t receiver_reply(input logic [1:0] f, input logic [7:0] d,
                                           input logic [3:0] s);
    resp_t r;
    r = '0;
    case (f)
      FUNC_PORT: begin
        if (d != port_prev) begin
          if (d == PORT_RESET) begin
            want_arm = 1'b1;
            byte_ptr = '0;
            bit_ptr  = '0;
          end else if (want_arm) begin
            if (d == PORT_ONE || d == PORT_ZERO) begin
              want_arm = 1'b0;
              rx_on    = 1'b0;
              r.sequence_abort = 1'b1;
            end else if (d == PORT_ARM) begin
              want_arm = 1'b0;
              rx_on    = 1'b1;
            end
          end else if (rx_on) begin
            if (d == PORT_ZERO) begin
              if (byte_ptr >= PktBytes && bit_ptr == 3'd0) begin
                pkt_full = 1'b1;
                rx_on    = 1'b0;
                r.packet_done = 1'b1;
              end else if (byte_ptr < PktBytes) begin
                pkt_bytes[byte_ptr[3:0]][bit_ptr] = 1'b0;
              end
              {byte_ptr, bit_ptr} = {byte_ptr, bit_ptr} + 8'd1;
            end else if (d == PORT_ONE) begin
              if (byte_ptr >= PktBytes) begin
                rx_on = 1'b0;
                r.sequence_abort = 1'b1;
              end else begin
                pkt_bytes[byte_ptr[3:0]][bit_ptr] = 1'b1;
                {byte_ptr, bit_ptr} = {byte_ptr, bit_ptr} + 8'd1;
              end
            end
            want_arm = rx_on;
          end else if (!port_prev[PortSelBit] && d[PortSelBit]) begin
            seat = (seat + 2'd1) & seat_mask();
          end
          port_prev = d;
        end
      end
      FUNC_PKT_READ: begin
        pkt_full    = 1'b0;
        r.read_data = pkt_bytes[s];
      end
      FUNC_JOY_WRITE: pad_bytes[s[1:0]] = d;
      default: r.read_data = pad_bytes[seat];
    endcase
    r.player_code  = CODE_BASE - 4'(seat);
    r.packet_ready = pkt_full;
    return r;
  endfunction

  task automatic push_beat(input logic [1:0] f, input logic [7:0] d, input logic [3:0] s,
                           input logic typed, input resp_t want);
    int    gap;
    resp_t r;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    data_value <= d;
    slot       <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // repeated port values do nothing and are not counted
    if (f != FUNC_PORT || d != port_prev) items_done++;
    r = receiver_reply(f, d, s);
    reply_due.push_back(typed ? want : r);
  endtask

  task automatic port(input logic [7:0] v);
    push_beat(FUNC_PORT, v, 4'($urandom), 1'b0, NO_RESP);
  endtask

  // Sender stops and the pipe drains before anything that needs an idle block.
  task automatic settle();
    in_valid <= 1'b0;
    while (reply_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seat_mode = m;
    seat      = seat & seat_mask();
  endtask

  // One packet: clean, noisy, cut by a bad-order bit, or closed by an extra one bit.
  task automatic send_packet(input bit clean);
    logic [127:0] payload;
    logic [7:0]   v;
    logic [7:0]   junk;
    int           kind;
    int           cut;
    int           n;
    bit           broken;
    kind = clean ? 0 : $urandom_range(0, 8);
    cut  = $urandom_range(0, 127);
    case ($urandom_range(0, 5))
      0:       payload = '0;
      1:       payload = '1;
      default: payload = {$urandom, $urandom, $urandom, $urandom};
    endcase
    broken = 1'b0;
    port(PORT_RESET);
    port(PORT_ARM);
    for (n = 0; n < 128 && !broken; n++) begin
      v = payload[n] ? PORT_ONE : PORT_ZERO;
      port(v);
      if (kind == 6 && $urandom_range(0, 7) == 0) begin
        junk = 8'($urandom_range(1, 255));
        if (junk == PORT_ONE || junk == PORT_ZERO || junk == PORT_ARM) junk = 8'h31;
        port($urandom_range(0, 1) ? v : junk);
      end
      if (kind == 7 && n == cut) begin
        port(payload[n] ? PORT_ZERO : PORT_ONE);
        broken = 1'b1;
      end else begin
        port(PORT_ARM);
        if (kind == 6 && $urandom_range(0, 7) == 0) port(PORT_ARM);
      end
    end
    if (!broken) begin
      port(kind == 8 ? PORT_ONE : PORT_ZERO);
      port(PORT_ARM);
    end
    repeat ($urandom_range(1, 4))
      push_beat(FUNC_PKT_READ, 8'($urandom), 4'($urandom), 1'b0, NO_RESP);
  endtask

  initial begin : stim
    int         phase_no;
    int         phase_end;
    int         k;
    logic [7:0] v;
    dir_tab = '{
      '{FUNC_JOY_READ,  8'h00, 4'd0,  1'b1, QUIET_F},
      '{FUNC_PKT_READ,  8'hFF, 4'd15, 1'b1, QUIET_F},
      '{FUNC_PORT,      PORT_ONE, 4'd0,  1'b1, ABORT_F},
      '{FUNC_PORT,      PORT_ARM, 4'd15, 1'b0, NO_RESP},
      '{FUNC_JOY_WRITE, 8'hFF, 4'd15, 1'b1, QUIET_F},
      '{FUNC_JOY_READ,  8'h00, 4'd0,  1'b1, QUIET_F},
      '{FUNC_JOY_WRITE, 8'h5A, 4'd4,  1'b0, NO_RESP},
      '{FUNC_JOY_READ,  8'h00, 4'd7,  1'b1, '{8'h5A, CODE_BASE, 1'b0, 1'b0, 1'b0}},
      '{FUNC_PORT,      8'hFF, 4'd0,  1'b0, NO_RESP},
      '{FUNC_PORT,      PORT_RESET, 4'd0, 1'b1, QUIET_F},
      '{FUNC_PORT,      PORT_ZERO,  4'd0, 1'b1, ABORT_F},
      '{FUNC_PORT,      PORT_RESET, 4'd0, 1'b0, NO_RESP},
      '{FUNC_PORT,      8'h55, 4'd0,  1'b0, NO_RESP},
      '{FUNC_PORT,      PORT_ARM,  4'd0, 1'b0, NO_RESP},
      '{FUNC_PORT,      PORT_ONE,  4'd0, 1'b0, NO_RESP},
      '{FUNC_PORT,      PORT_ONE,  4'd0, 1'b0, NO_RESP},
      '{FUNC_PORT,      PORT_ARM,  4'd0, 1'b0, NO_RESP},
      '{FUNC_PORT,      PORT_ZERO, 4'd0, 1'b0, NO_RESP},
      '{FUNC_PORT,      8'h77, 4'd0,  1'b0, NO_RESP},
      '{FUNC_PORT,      PORT_ONE,  4'd0, 1'b0, NO_RESP},
      '{FUNC_PKT_READ,  8'h00, 4'd0,  1'b0, NO_RESP},
      '{FUNC_JOY_READ,  8'hFF, 4'd15, 1'b0, NO_RESP}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_mode(MODE_ONE);
    for (k = 0; k < 22; k++)
      push_beat(dir_tab[k].func, dir_tab[k].data, dir_tab[k].slot, dir_tab[k].typed,
                dir_tab[k].want);
    settle();

    phase_no = 0;
    while (items_done < ItemTarget) begin
      case (phase_no % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      set_mode(2'((3 - phase_no + phase_no / 4) % 4));
      if (phase_no == 0) begin
        // output held off while the first part of a whole packet keeps coming
        hold_req++;
        send_packet(1'b1);
      end
      phase_end = items_done + PhaseItems;
      while (items_done < phase_end && items_done < ItemTarget) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_packet(1'b0);
          5, 6: begin
            // player-select edges, live only between packets
            repeat ($urandom_range(4, 12)) begin
              case ($urandom_range(0, 3))
                0:       v = PORT_ONE;
                1:       v = PORT_ZERO;
                2:       v = PORT_ARM;
                default: v = 8'($urandom_range(1, 255));
              endcase
              port(v);
            end
          end
          7: repeat ($urandom_range(2, 8))
               push_beat($urandom_range(0, 1) ? FUNC_JOY_WRITE : FUNC_JOY_READ,
                         8'($urandom), 4'($urandom), 1'b0, NO_RESP);
          8: repeat ($urandom_range(4, 10))
               push_beat(2'($urandom), 8'($urandom), 4'($urandom), 1'b0, NO_RESP);
          default: repeat ($urandom_range(1, 6))
                     push_beat(FUNC_PKT_READ, 8'($urandom), 4'($urandom), 1'b0, NO_RESP);
        endcase
      end
      settle();
      phase_no++;
    end

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (reply_due.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t ns: result beat expected none, got read_data 0x%0h", $time,
                   read_data);
      end else begin
        due = reply_due.pop_front();
        check_field("read_data", due.read_data, read_data);
        check_field("player_code", due.player_code, player_code);
        check_field("packet_ready", due.packet_ready, packet_ready);
        check_field("packet_done", due.packet_done, packet_done);
        check_field("sequence_abort", due.sequence_abort, sequence_abort);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
